@@ design/xdu_pkg.sv @@
// ----------------------------------------------------------------------------
// xdu_pkg
// Types and constants shared by the ungapped x-drop extender and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package xdu_pkg;

    localparam int POS_W     = 32;
    localparam int SCORE_W   = 16;
    localparam int BEST_W    = 31;
    localparam int MAXDROP_W = 16;
    localparam int DROP_W    = MAXDROP_W + 1;
    localparam int DIFF_W    = DROP_W + 1;

    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [BEST_W-1:0]    best_t;
    typedef logic [MAXDROP_W-1:0] max_drop_t;
    typedef logic [DROP_W-1:0]    drop_t;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_BWD   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CONT    = 2'd0,
        ST_FWD_END = 2'd1,
        ST_DONE    = 2'd2,
        ST_OVFL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_FWD  = 2'd1,
        PH_BWD  = 2'd2
    } phase_t;

    localparam best_t BEST_MAX = {BEST_W{1'b1}};

endpackage

`default_nettype wire

@@ design/xdu_in_if.sv @@
// ----------------------------------------------------------------------------
// xdu_in_if
// Command channel: start with seeds, or one forward or backward pair score.
// ----------------------------------------------------------------------------
`default_nettype none

interface xdu_in_if
    import xdu_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic [POS_W-1:0]          seed_first;
    logic [POS_W-1:0]          seed_second;
    logic signed [SCORE_W-1:0] pair_score;

    modport source (
        output valid, cmd, seed_first, seed_second, pair_score,
        input  ready
    );

    modport sink (
        input  valid, cmd, seed_first, seed_second, pair_score,
        output ready
    );
endinterface

`default_nettype wire

@@ design/xdu_out_if.sv @@
// ----------------------------------------------------------------------------
// xdu_out_if
// Result channel: status, best score and the reported segment.
// ----------------------------------------------------------------------------
`default_nettype none

interface xdu_out_if
    import xdu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [BEST_W-1:0] best_score;
    logic [POS_W-1:0]  start_first;
    logic [POS_W-1:0]  start_second;
    logic [POS_W-1:0]  length;

    modport source (
        output valid, status, best_score, start_first, start_second, length,
        input  ready
    );

    modport sink (
        input  valid, status, best_score, start_first, start_second, length,
        output ready
    );
endinterface

`default_nettype wire

@@ design/xdrop_ungapped_extender.sv @@
// a command passes through the input register, then the result register, to the result channel
// throughput: one command per cycle while the result channel is ready
// an input register and a result register decouple the two channels
// reset: asynchronous, clears max_drop, score, drop, positions; phase goes idle
// ----------------------------------------------------------------------------
// xdrop_ungapped_extender
// Ungapped x-drop extension of a seed hit, one pair score per command.
// ----------------------------------------------------------------------------
`default_nettype none

module xdrop_ungapped_extender
    import xdu_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [15:0]     cfg_wdata,
    xdu_in_if.sink               cmd_ch,
    xdu_out_if.source            res_ch
);

    // input stage
    logic                      in_valid_reg;
    cmd_t                      in_cmd_reg;
    pos_t                      in_seed_first_reg;
    pos_t                      in_seed_second_reg;
    logic signed [SCORE_W-1:0] in_score_reg;

    // result stage
    logic    out_valid_reg;
    status_t out_status_reg;
    best_t   out_best_reg;
    pos_t    out_sf_reg;
    pos_t    out_ss_reg;
    pos_t    out_len_reg;

    // extension state
    max_drop_t max_drop_reg;
    best_t     total_reg,     total_next;
    drop_t     drop_reg,      drop_next;
    pos_t      best_end_reg,  best_end_next;
    pos_t      best_beg_reg,  best_beg_next;
    pos_t      seed_f_reg,    seed_f_next;
    pos_t      seed_s_reg,    seed_s_next;
    pos_t      cursor_reg,    cursor_next;
    phase_t    phase_reg,     phase_next;

    status_t   status_c;
    pos_t      sf_c;
    pos_t      ss_c;
    pos_t      len_c;

    logic                     advance;
    logic                     step_fwd;
    logic                     step_bwd;
    pos_t                     cursor_step;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        neg_diff;
    logic [SCORE_W:0]         gain;
    logic [BEST_W:0]          sum;
    logic                     new_best;
    logic                     ovfl;
    logic                     exceed;

    assign advance      = in_valid_reg && (!out_valid_reg || res_ch.ready);
    assign cmd_ch.ready = !in_valid_reg || advance;

    assign step_fwd    = (in_cmd_reg == CMD_FWD) && (phase_reg == PH_FWD);
    assign step_bwd    = (in_cmd_reg == CMD_BWD) && (phase_reg == PH_BWD);
    assign cursor_step = step_fwd ? cursor_reg + pos_t'(1) : cursor_reg - pos_t'(1);

    assign diff     = $signed({1'b0, drop_reg})
                    - {{(DIFF_W-SCORE_W){in_score_reg[SCORE_W-1]}}, in_score_reg};
    assign neg_diff = -diff;
    assign gain     = neg_diff[SCORE_W:0];
    assign sum      = {1'b0, total_reg} + {{(BEST_W-SCORE_W){1'b0}}, gain};
    assign new_best = diff[DIFF_W-1];
    assign ovfl     = new_best && sum[BEST_W];
    assign exceed   = !new_best && (diff[DROP_W-1:0] > {1'b0, max_drop_reg});

    always_comb
    begin
        total_next    = total_reg;
        drop_next     = drop_reg;
        best_end_next = best_end_reg;
        best_beg_next = best_beg_reg;
        seed_f_next   = seed_f_reg;
        seed_s_next   = seed_s_reg;
        cursor_next   = cursor_reg;
        phase_next    = phase_reg;
        status_c      = ST_CONT;
        sf_c          = '0;
        ss_c          = '0;
        len_c         = '0;

        if (in_cmd_reg == CMD_START)
        begin
            seed_f_next   = in_seed_first_reg;
            seed_s_next   = in_seed_second_reg;
            total_next    = '0;
            drop_next     = '0;
            best_end_next = in_seed_first_reg;
            best_beg_next = in_seed_first_reg;
            cursor_next   = in_seed_first_reg;
            phase_next    = PH_FWD;
        end
        else if (step_fwd || step_bwd)
        begin
            cursor_next = cursor_step;
            drop_next   = new_best ? '0 : diff[DROP_W-1:0];
            priority if (ovfl)
            begin
                total_next = BEST_MAX;
                status_c   = ST_OVFL;
                phase_next = PH_IDLE;
            end
            else if (new_best)
            begin
                total_next = sum[BEST_W-1:0];
                if (step_fwd)
                begin
                    best_end_next = cursor_step;
                end
                else
                begin
                    best_beg_next = cursor_step;
                end
            end
            else if (exceed)
            begin
                if (step_fwd)
                begin
                    status_c      = ST_FWD_END;
                    drop_next     = '0;
                    cursor_next   = seed_f_reg;
                    best_beg_next = seed_f_reg;
                    phase_next    = PH_BWD;
                end
                else
                begin
                    status_c   = ST_DONE;
                    sf_c       = best_beg_reg;
                    ss_c       = best_beg_reg + seed_s_reg - seed_f_reg;
                    len_c      = best_end_reg - best_beg_reg;
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                // drop still within the limit
                status_c = ST_CONT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_drop_reg  <= '0;
            total_reg     <= '0;
            drop_reg      <= '0;
            best_end_reg  <= '0;
            best_beg_reg  <= '0;
            seed_f_reg    <= '0;
            seed_s_reg    <= '0;
            cursor_reg    <= '0;
            phase_reg     <= PH_IDLE;
        end
        else
        begin
            if (cfg_we)
            begin
                max_drop_reg <= cfg_wdata;
            end
            if (cmd_ch.ready)
            begin
                in_valid_reg <= cmd_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
                drop_reg      <= drop_next;
                best_end_reg  <= best_end_next;
                best_beg_reg  <= best_beg_next;
                seed_f_reg    <= seed_f_next;
                seed_s_reg    <= seed_s_next;
                cursor_reg    <= cursor_next;
                phase_reg     <= phase_next;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            in_cmd_reg         <= cmd_t'(cmd_ch.cmd);
            in_seed_first_reg  <= cmd_ch.seed_first;
            in_seed_second_reg <= cmd_ch.seed_second;
            in_score_reg       <= cmd_ch.pair_score;
        end
        if (advance)
        begin
            out_status_reg <= status_c;
            out_best_reg   <= total_next;
            out_sf_reg     <= sf_c;
            out_ss_reg     <= ss_c;
            out_len_reg    <= len_c;
        end
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.status       = out_status_reg;
    assign res_ch.best_score   = out_best_reg;
    assign res_ch.start_first  = out_sf_reg;
    assign res_ch.start_second = out_ss_reg;
    assign res_ch.length       = out_len_reg;

endmodule

`default_nettype wire
